// ===== rtl/core/scbe_pkg.sv =====
// ----------------------------------------------------------------------------
// scbe_pkg
// Shared types and constants for the sound code byte encoder: request codes,
// code types, byte prefixes, dictionary geometry and pipeline item structs.
// ----------------------------------------------------------------------------
package scbe_pkg;

    // Dictionary geometry
    localparam int DICT_ENTRIES = 128;
    localparam int CHUNK        = (DICT_ENTRIES < 32) ? DICT_ENTRIES : 32;
    localparam int NCHUNK       = (DICT_ENTRIES + CHUNK - 1) / CHUNK;
    localparam int LOC_W        = (CHUNK > 1) ? $clog2(CHUNK) : 1;
    localparam int IDX_W        = 9;

    // Field widths
    localparam int REQ_W  = 2;
    localparam int CODE_W = 40;
    localparam int SLOT_W = 7;
    localparam int BYTE_W = 8;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // Code types (bits 39..32)
    localparam logic [BYTE_W-1:0] TYPE_VOL   = 8'd1;
    localparam logic [BYTE_W-1:0] TYPE_FREQ  = 8'd2;
    localparam logic [BYTE_W-1:0] TYPE_CTRL  = 8'd4;
    localparam logic [BYTE_W-1:0] TYPE_FULL  = 8'd7;
    localparam logic [BYTE_W-1:0] TYPE_LABEL = 8'd8;
    localparam logic [BYTE_W-1:0] TYPE_SPAN  = 8'd9;

    // Byte prefixes
    localparam logic [15:0]       WORD_BASE   = 16'hf000;
    localparam logic [BYTE_W-1:0] PFX_FULL    = 8'ha0;
    localparam logic [BYTE_W-1:0] PFX_CTRL    = 8'h90;
    localparam logic [BYTE_W-1:0] PFX_FREQ    = 8'hc0;
    localparam logic [BYTE_W-1:0] PFX_VOL     = 8'he0;
    localparam logic [BYTE_W-1:0] PFX_OTHER   = 8'h80;

    // Input item
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CODE_W-1:0] code;
        logic [SLOT_W-1:0] entry_slot;
        logic [CODE_W-1:0] entry_key;
    } t_in;

    // Result item
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_byte;
    } t_out;

    // Item inside the dictionary search pipeline
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CODE_W-1:0] code;
        logic [SLOT_W-1:0] entry_slot;
        logic [CODE_W-1:0] entry_key;
        logic              hit;
        logic [BYTE_W-1:0] slot;
    } t_pipe;

    // Formatted bytes of one code, byte 0 leaves first
    typedef struct packed {
        logic [2:0][BYTE_W-1:0] bytes;
        logic [1:0]             cnt;
    } t_fmt;

endpackage

// ===== rtl/core/scbe_dict_stage.sv =====
// ----------------------------------------------------------------------------
// scbe_dict_stage
// One pipeline stage that owns a chunk of dictionary entries. Loads and clears
// update the chunk as they pass, encodes are compared against it, so every
// item sees exactly the dictionary left by the items ahead of it.
// ----------------------------------------------------------------------------
module scbe_dict_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [scbe_pkg::IDX_W-1:0] i_base,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  scbe_pkg::t_pipe            i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output scbe_pkg::t_pipe            o_item
);
    import scbe_pkg::*;

    logic [CODE_W-1:0] r_keys [CHUNK];
    logic [CHUNK-1:0]  r_keyv;
    logic [CHUNK-1:0]  match;
    logic [CHUNK-1:0]  wsel;
    logic              hit_here;
    logic [LOC_W-1:0]  hit_loc;
    t_pipe             r_item;
    t_pipe             n_item;
    logic              r_valid;
    logic              move;

    assign o_ready = !r_valid || i_ready;
    assign move    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // per-entry compare and write select
    always_comb begin
        for (int j = 0; j < CHUNK; j++) begin
            match[j] = r_keyv[j] && (r_keys[j] == i_item.code);
            wsel[j]  = (IDX_W'(i_item.entry_slot) == i_base + IDX_W'(j))
                       && ((i_base + IDX_W'(j)) < IDX_W'(DICT_ENTRIES));
        end
    end

    // lowest matching entry wins
    always_comb begin
        hit_here = 1'b0;
        hit_loc  = '0;
        for (int j = CHUNK - 1; j >= 0; j--) begin
            if (match[j]) begin
                hit_here = 1'b1;
                hit_loc  = LOC_W'(j);
            end
        end
    end

    // earlier chunks hold lower slots, keep their hit
    always_comb begin
        n_item = i_item;
        if (!i_item.hit && hit_here) begin
            n_item.hit  = 1'b1;
            n_item.slot = BYTE_W'(i_base + IDX_W'(hit_loc));
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_item <= n_item;
        end
    end

    // entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keyv <= '0;
        end else if (move) begin
            if (i_item.req_type == REQ_CLEAR) begin
                r_keyv <= '0;
            end else if (i_item.req_type == REQ_LOAD) begin
                for (int j = 0; j < CHUNK; j++) begin
                    if (wsel[j]) begin
                        r_keyv[j] <= 1'b1;
                    end
                end
            end
        end
    end

    // entry keys, no reset
    always_ff @(posedge i_clk) begin
        if (move && (i_item.req_type == REQ_LOAD)) begin
            for (int j = 0; j < CHUNK; j++) begin
                if (wsel[j]) begin
                    r_keys[j] <= i_item.entry_key;
                end
            end
        end
    end

endmodule

// ===== rtl/core/scbe_format.sv =====
// ----------------------------------------------------------------------------
// scbe_format
// Builds the zero to three bytes of one code from its fields and the
// dictionary hit. Items that produce no bytes are dropped here.
// ----------------------------------------------------------------------------
module scbe_format (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  scbe_pkg::t_pipe i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output scbe_pkg::t_fmt  o_item
);
    import scbe_pkg::*;

    logic [BYTE_W-1:0] ty;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] f;
    logic [BYTE_W-1:0] v;
    logic [BYTE_W-1:0] s;
    logic              sus_en;
    logic [BYTE_W-1:0] sus;
    logic [15:0]       word;
    t_fmt              n_fmt;
    t_fmt              r_fmt;
    logic              r_valid;

    assign ty     = i_item.code[39:32];
    assign c      = i_item.code[31:24];
    assign f      = i_item.code[23:16];
    assign v      = i_item.code[15:8];
    assign s      = i_item.code[7:0];
    assign sus_en = (s > 8'd1);
    assign sus    = PFX_OTHER + (s - 8'd1);
    assign word   = WORD_BASE + i_item.code[15:0];

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_fmt;

    // byte layout per code type
    always_comb begin
        n_fmt.bytes = '0;
        n_fmt.cnt   = 2'd0;
        unique case (ty)
            TYPE_SPAN: begin
                if (i_item.hit) begin
                    n_fmt.bytes[0] = i_item.slot;
                    n_fmt.cnt      = 2'd1;
                end else begin
                    n_fmt.bytes[0] = word[7:0];
                    n_fmt.bytes[1] = word[15:8];
                    n_fmt.cnt      = 2'd2;
                end
            end
            TYPE_LABEL: begin
                n_fmt.cnt = 2'd0;
            end
            TYPE_FULL: begin
                if (i_item.hit) begin
                    n_fmt.bytes[0] = i_item.slot;
                    n_fmt.cnt      = 2'd1;
                end else begin
                    n_fmt.bytes[0] = PFX_FULL + f;
                    n_fmt.bytes[1] = {c[3:0], 4'h0} | v;
                    n_fmt.bytes[2] = sus;
                    n_fmt.cnt      = sus_en ? 2'd3 : 2'd2;
                end
            end
            TYPE_CTRL: begin
                n_fmt.bytes[0] = PFX_CTRL + c;
                n_fmt.bytes[1] = sus;
                n_fmt.cnt      = sus_en ? 2'd2 : 2'd1;
            end
            TYPE_FREQ: begin
                n_fmt.bytes[0] = PFX_FREQ + f;
                n_fmt.bytes[1] = sus;
                n_fmt.cnt      = sus_en ? 2'd2 : 2'd1;
            end
            TYPE_VOL: begin
                n_fmt.bytes[0] = PFX_VOL + v;
                n_fmt.bytes[1] = sus;
                n_fmt.cnt      = sus_en ? 2'd2 : 2'd1;
            end
            default: begin
                n_fmt.bytes[0] = (i_item.code == '0) ? 8'h00 : (PFX_OTHER + s);
                n_fmt.cnt      = 2'd1;
            end
        endcase
        if (i_item.req_type != REQ_ENCODE) begin
            n_fmt.cnt = 2'd0;
        end
    end

    // stage register, empty items do not occupy it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && (n_fmt.cnt != 2'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_fmt <= n_fmt;
        end
    end

endmodule

// ===== rtl/core/scbe_serial.sv =====
// ----------------------------------------------------------------------------
// scbe_serial
// Output register that sends the bytes of one code one per cycle while the
// receiver is ready and takes the next code in the cycle its last byte leaves.
// ----------------------------------------------------------------------------
module scbe_serial (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  scbe_pkg::t_fmt i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output scbe_pkg::t_out o_data
);
    import scbe_pkg::*;

    logic [2:0][BYTE_W-1:0] r_b;
    logic [1:0]             r_cnt;
    logic                   take;
    logic                   load;

    assign o_valid          = (r_cnt != 2'd0);
    assign o_data.out_byte  = r_b[0];
    assign o_data.last_byte = (r_cnt == 2'd1);
    assign take             = o_valid && i_ready;
    assign o_ready          = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);
    assign load             = i_valid && o_ready;

    // bytes left of the current code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (load) begin
            r_cnt <= i_item.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // byte shifter
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_b <= i_item.bytes;
        end else if (take) begin
            r_b <= {8'h00, r_b[2], r_b[1]};
        end
    end

endmodule

// ===== rtl/core/sound_code_byte_encoder_core.sv =====
// ----------------------------------------------------------------------------
// sound_code_byte_encoder_core
// Encodes 40-bit sound command codes into byte items through a pipelined
// dictionary search, a byte formatter and a byte serializer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready/i_data) takes encode, dictionary load and
//   dictionary clear requests. Output channel (o_valid/i_ready/o_data) gives
//   one item per encoded byte, last_byte set on the final byte of a code.
//   The dictionary is split into NCHUNK chunks of CHUNK entries; each chunk
//   sits in its own pipeline stage and is updated as requests pass it, so
//   every request sees the dictionary in request order.
//   An accepted encode passes the NCHUNK chunk stage registers, the format
//   register and the serializer register before its first byte is valid.
//   Throughput: one request can enter every cycle while the pipeline is not
//   stalled. The serializer sends one byte per cycle while the receiver is
//   ready, and a code has one to three bytes.
//   Loads, clears and codes without bytes never reach the output.
//   Reset (synchronous, active low) empties the pipeline and clears every
//   dictionary valid bit; keys keep no reset value.
//   When the receiver stalls, the output byte holds and the pipeline keeps
//   filling until every stage is occupied, then o_ready drops.
// ----------------------------------------------------------------------------
module sound_code_byte_encoder_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  scbe_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output scbe_pkg::t_out o_data
);
    import scbe_pkg::*;

    t_pipe         st_item  [NCHUNK+1];
    logic [NCHUNK:0] st_valid;
    logic [NCHUNK:0] st_ready;
    logic          fmt_valid;
    logic          fmt_ready;
    t_fmt          fmt_item;

    // incoming request enters the first chunk stage
    always_comb begin
        st_item[0].req_type   = i_data.req_type;
        st_item[0].code       = i_data.code;
        st_item[0].entry_slot = i_data.entry_slot;
        st_item[0].entry_key  = i_data.entry_key;
        st_item[0].hit        = 1'b0;
        st_item[0].slot       = '0;
    end
    assign st_valid[0] = i_valid;
    assign o_ready     = st_ready[0];

    // dictionary search chain
    for (genvar k = 0; k < NCHUNK; k++) begin : g_chunk
        scbe_dict_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_base  (IDX_W'(k * CHUNK)),
            .i_valid (st_valid[k]),
            .o_ready (st_ready[k]),
            .i_item  (st_item[k]),
            .o_valid (st_valid[k+1]),
            .i_ready (st_ready[k+1]),
            .o_item  (st_item[k+1])
        );
    end

    // byte formatting
    scbe_format u_format (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid[NCHUNK]),
        .o_ready (st_ready[NCHUNK]),
        .i_item  (st_item[NCHUNK]),
        .o_valid (fmt_valid),
        .i_ready (fmt_ready),
        .o_item  (fmt_item)
    );

    // byte serializer / output register
    scbe_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fmt_valid),
        .o_ready (fmt_ready),
        .i_item  (fmt_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

`ifndef SYNTHESIS
    // bytes of one code leave without gaps
    a_bytes_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_data.last_byte) |=> o_valid)
        else $error("gap inside the bytes of one code");

    // reset empties the output
    a_reset_no_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // reset empties the whole pipeline, so input is ready
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("input not ready right after reset");

    // a formatted item is only passed on when it has bytes
    a_fmt_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fmt_valid |-> (fmt_item.cnt != 2'd0))
        else $error("empty code reached the serializer");
`endif

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sound_code_byte_encoder_core. A scoreboard class keeps
// its own copy of the code dictionary, predicts the bytes of every accepted
// encode request and checks each output item against the oldest prediction.
// Directed requests cover the byte layouts, wrap-around, dictionary hits and
// clears. Random traffic follows, with idle cycles on both channels.
// ----------------------------------------------------------------------------
import scbe_pkg::*;

// Dictionary copy, byte prediction and output checking
class code_byte_tracker;
    logic [CODE_W-1:0] dict_key  [DICT_ENTRIES];
    bit                dict_live [DICT_ENTRIES];
    t_out              pending_bytes [$];
    int unsigned       errors;

    function new();
        foreach (dict_live[i]) dict_live[i] = 1'b0;
        errors = 0;
    endfunction

    function int pending();
        return pending_bytes.size();
    endfunction

    // Lowest valid slot holding the code, -1 on a miss
    function int find_slot(logic [CODE_W-1:0] code);
        for (int i = 0; i < DICT_ENTRIES; i++) begin
            if (dict_live[i] && dict_key[i] == code) return i;
        end
        return -1;
    endfunction

    // Update the dictionary or queue the bytes of one accepted request
    function void note_request(t_in item);
        logic [BYTE_W-1:0] kind, c, f, v, s;
        logic [15:0]       word;
        logic [BYTE_W-1:0] seq [$];
        int                hit;
        t_out              exp_item;

        kind = item.code[39:32];
        c    = item.code[31:24];
        f    = item.code[23:16];
        v    = item.code[15:8];
        s    = item.code[7:0];
        case (item.req_type)
            REQ_LOAD: begin
                dict_key[item.entry_slot]  = item.entry_key;
                dict_live[item.entry_slot] = 1'b1;
            end
            REQ_CLEAR: begin
                foreach (dict_live[i]) dict_live[i] = 1'b0;
            end
            REQ_ENCODE: begin
                hit = find_slot(item.code);
                if ((kind == TYPE_SPAN || kind == TYPE_FULL) && hit >= 0) begin
                    seq = {seq, hit[BYTE_W-1:0]};
                end else if (kind == TYPE_SPAN) begin
                    word = WORD_BASE + item.code[15:0];
                    seq = {seq, word[7:0]};
                    seq = {seq, word[15:8]};
                end else if (kind == TYPE_LABEL) begin
                    // labels produce no bytes
                end else if (kind == TYPE_FULL || kind == TYPE_CTRL ||
                             kind == TYPE_FREQ || kind == TYPE_VOL) begin
                    if (kind == TYPE_FULL) begin
                        seq = {seq, PFX_FULL + f};
                        seq = {seq, {c[3:0], 4'h0} | v};
                    end else if (kind == TYPE_CTRL) begin
                        seq = {seq, PFX_CTRL + c};
                    end else if (kind == TYPE_FREQ) begin
                        seq = {seq, PFX_FREQ + f};
                    end else begin
                        seq = {seq, PFX_VOL + v};
                    end
                    // sustain byte only above one
                    if (s > 8'd1) seq = {seq, PFX_OTHER + (s - 8'd1)};
                end else if (item.code == '0) begin
                    seq = {seq, 8'h00};
                end else begin
                    seq = {seq, PFX_OTHER + item.code[7:0]};
                end
                foreach (seq[i]) begin
                    exp_item.out_byte  = seq[i];
                    exp_item.last_byte = (i == seq.size() - 1);
                    pending_bytes = {pending_bytes, exp_item};
                end
            end
            default: begin
                // spare request type is ignored
            end
        endcase
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_byte(t_out got);
        t_out want;
        if (pending_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h last %0b", got.out_byte, got.last_byte));
        end else begin
            want = pending_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
            if (got.last_byte !== want.last_byte)
                report($sformatf("last_byte %0b, want %0b on byte %02h",
                                 got.last_byte, want.last_byte, want.out_byte));
        end
    endtask
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 120;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;
    bit   calm;

    code_byte_tracker tracker = new();
    logic [CODE_W-1:0] known_keys [$];

    sound_code_byte_encoder_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver with random stalls
    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 19);
    end

    // Observe both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) tracker.note_request(i_data);
            if (o_valid && i_ready) tracker.check_byte(o_data);
        end
    end

    // Watchdog: too long without any handshake
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
            else quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [CODE_W-1:0] rand_code();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[CODE_W-1:0];
    endfunction

    function automatic t_in make_item(logic [REQ_W-1:0] req, logic [CODE_W-1:0] code,
                                      logic [SLOT_W-1:0] slot, logic [CODE_W-1:0] key);
        t_in item;
        item.req_type   = req;
        item.code       = code;
        item.entry_slot = slot;
        item.entry_key  = key;
        return item;
    endfunction

    // Present one item, with an optional random gap, and wait for acceptance
    task automatic send_item(t_in item);
        while (!calm && $urandom_range(99) < 19) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic encode(logic [CODE_W-1:0] code);
        send_item(make_item(REQ_ENCODE, code, SLOT_W'($urandom()), rand_code()));
    endtask

    task automatic load(logic [SLOT_W-1:0] slot, logic [CODE_W-1:0] key);
        send_item(make_item(REQ_LOAD, rand_code(), slot, key));
    endtask

    // Hold the sender until every predicted byte has left
    task automatic wait_empty();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    // Random code with a chosen type; small sustain values are common
    function automatic logic [CODE_W-1:0] typed_code();
        logic [CODE_W-1:0] code;
        code = rand_code();
        case ($urandom_range(8))
            0: code[39:32] = 8'd0;
            1: code[39:32] = TYPE_VOL;
            2: code[39:32] = TYPE_FREQ;
            3: code[39:32] = TYPE_CTRL;
            4, 5: code[39:32] = TYPE_FULL;
            6: code[39:32] = TYPE_LABEL;
            7: code[39:32] = TYPE_SPAN;
            default: ;
        endcase
        if ($urandom_range(3) == 0) code[7:0] = 8'($urandom_range(2));
        if ($urandom_range(40) == 0) code = '0;
        return code;
    endfunction

    localparam logic [CODE_W-1:0] FULL_KEY = {TYPE_FULL, 32'h1234_5602};
    localparam logic [CODE_W-1:0] SPAN_KEY = {TYPE_SPAN, 32'h0000_0abc};

    // Main sequence
    initial begin : stimulus
        int   done;
        int   pick;
        t_in  item;
        logic [CODE_W-1:0] key;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        calm    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: byte layouts and edge values
        encode('0);
        encode({8'd0, 32'h0000_00ff});
        encode({TYPE_VOL, 32'h0000_ff00});
        encode({TYPE_VOL, 32'h0000_0001});
        encode({TYPE_FREQ, 32'h003f_0002});
        encode({TYPE_CTRL, 32'h7000_00ff});
        encode({TYPE_FULL, 32'hffff_ffff});
        encode({TYPE_FULL, 32'h0000_0001});
        encode({TYPE_LABEL, 32'hffff_ffff});
        encode({TYPE_SPAN, 32'hffff_0000});
        encode({TYPE_SPAN, 32'h0000_ffff});
        encode({TYPE_SPAN, 32'h0000_0fff});
        encode({8'hff, 32'hffff_ffff});
        // Dictionary: hits, lowest slot wins, spare type ignored, clear
        load(7'd5, FULL_KEY);
        load(7'd127, SPAN_KEY);
        load(7'd0, SPAN_KEY);
        encode(FULL_KEY);
        encode(SPAN_KEY);
        load(7'd3, FULL_KEY);
        load(7'd9, {TYPE_CTRL, 32'h4400_0005});
        encode({TYPE_CTRL, 32'h4400_0005});
        send_item(make_item(REQ_SPARE, rand_code(), 7'd3, rand_code()));
        encode(FULL_KEY);
        send_item(make_item(REQ_CLEAR, rand_code(), 7'd127, rand_code()));
        encode(FULL_KEY);
        load(7'd127, SPAN_KEY);
        encode(SPAN_KEY);
        known_keys = {known_keys, FULL_KEY};
        known_keys = {known_keys, SPAN_KEY};
        wait_empty();

        // Random traffic; a stretch in the middle runs without idling
        done = 0;
        while (done < RANDOM_ITEMS) begin
            calm = (done >= 50 && done < 90);
            if (done == 110) wait_empty();
            pick = $urandom_range(99);
            if (pick < 55) begin
                if ($urandom_range(9) < 3) encode(known_keys[$urandom_range(known_keys.size() - 1)]);
                else encode(typed_code());
                done++;
            end else if (pick < 82) begin
                key = rand_code();
                if ($urandom_range(4) != 0) key[39:32] = $urandom_range(1) ? TYPE_FULL : TYPE_SPAN;
                load(SLOT_W'($urandom()), key);
                if (known_keys.size() >= 32) void'(known_keys.pop_front());
                known_keys = {known_keys, key};
                done++;
            end else if (pick < 85) begin
                send_item(make_item(REQ_CLEAR, rand_code(), SLOT_W'($urandom()), rand_code()));
                done++;
            end else if (pick < 88) begin
                send_item(make_item(REQ_SPARE, rand_code(), SLOT_W'($urandom()), rand_code()));
            end else begin
                item = make_item(REQ_ENCODE, rand_code(), SLOT_W'($urandom()), rand_code());
                send_item(item);
                done++;
            end
        end
        calm = 1'b0;

        // Drain and let stray bytes show up
        wait_empty();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/scbe_pkg.sv
rtl/core/scbe_dict_stage.sv
rtl/core/scbe_format.sv
rtl/core/scbe_serial.sv
rtl/core/sound_code_byte_encoder_core.sv
test/testbench.sv
